>>> src/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// shared constants and codes of the roulette wheel selector
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int MAX_POP    = 256;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_POP);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int SUM_BITS   = 2 * VALUE_BITS + IDX_BITS;

    localparam int ACTION_BITS = 2;
    localparam int CHROM_BITS  = 16;
    localparam int DRAW_BITS   = 48;
    localparam int PIDX_BITS   = 8;
    localparam int STATUS_BITS = 2;
    localparam int DIV_CNT_BITS = $clog2(DRAW_BITS);

    localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_SELECT = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

endpackage

>>> src/rws_in_if.sv
// ----------------------------------------------------------------------------
// rws_in_if
// input word channel: action, chromosome and draw
// ----------------------------------------------------------------------------
interface rws_in_if;

    logic                               valid;
    logic                               ready;
    logic [rws_pkg::ACTION_BITS-1:0]    action;
    logic [rws_pkg::CHROM_BITS-1:0]     chromosome;
    logic [rws_pkg::DRAW_BITS-1:0]      draw;

    modport source (output valid, output action, output chromosome, output draw,
                    input ready);
    modport sink   (input valid, input action, input chromosome, input draw,
                    output ready);

endinterface

>>> src/rws_out_if.sv
// ----------------------------------------------------------------------------
// rws_out_if
// result word channel: picked index, picked value and status
// ----------------------------------------------------------------------------
interface rws_out_if;

    logic                               valid;
    logic                               ready;
    logic [rws_pkg::PIDX_BITS-1:0]      picked_index;
    logic [rws_pkg::CHROM_BITS-1:0]     picked_value;
    logic [rws_pkg::STATUS_BITS-1:0]    status;

    modport source (output valid, output picked_index, output picked_value,
                    output status, input ready);
    modport sink   (input valid, input picked_index, input picked_value,
                    input status, output ready);

endinterface

>>> src/rws_ram.sv
// ----------------------------------------------------------------------------
// rws_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/roulette_wheel_selector_top.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selector_top
// fitness proportionate parent selection over a stored population
// ----------------------------------------------------------------------------
// input channel i_in carries one word per command: clear, load or select.
// output channel o_out returns exactly one word per command, in order.
// the block takes a word only while its sequencer is idle; a finished
// result sits in the output register, so the next word is taken even
// while the receiver stalls. a new result waits in the sequencer until
// the output register is free.
// steps from accept to result valid:
//   clear, refused load, empty select, unused code: the result step only
//   load: a multiply step, an add and table write step, the result step
//   select: the restoring subtract unit for the modulo, a binary search of
//   up to 8 steps (one cumulative ram read each), then the value read and
//   the result
// one word is in flight at a time.
// reset (synchronous, active low) empties the population and drops any
// pending result; the value and cumulative rams are not cleared.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rws_in_if.sink        i_in,
    rws_out_if.source     o_out
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_LOAD_MUL = 8'b0000_0010,
        S_LOAD_ADD = 8'b0000_0100,
        S_DIV      = 8'b0000_1000,
        S_SADDR    = 8'b0001_0000,
        S_SCMP     = 8'b0010_0000,
        S_FWAIT    = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } t_state;

    t_state                                r_state, n_state;
    logic [rws_pkg::CNT_BITS-1:0]          r_count, n_count;
    logic [rws_pkg::SUM_BITS-1:0]          r_total, n_total;
    logic [rws_pkg::VALUE_BITS-1:0]        r_chrom, n_chrom;
    logic [2*rws_pkg::VALUE_BITS-1:0]      r_prod, n_prod;
    logic [rws_pkg::DRAW_BITS-1:0]         r_draw, n_draw;
    logic [rws_pkg::SUM_BITS-1:0]          r_rem, n_rem;
    logic [rws_pkg::DIV_CNT_BITS-1:0]      r_div_cnt, n_div_cnt;
    logic [rws_pkg::IDX_BITS-1:0]          r_lo, n_lo;
    logic [rws_pkg::IDX_BITS-1:0]          r_hi, n_hi;
    logic [rws_pkg::IDX_BITS-1:0]          r_mid, n_mid;
    logic [rws_pkg::PIDX_BITS-1:0]         r_res_idx, n_res_idx;
    logic [rws_pkg::CHROM_BITS-1:0]        r_res_val, n_res_val;
    logic [rws_pkg::STATUS_BITS-1:0]       r_res_st, n_res_st;
    logic                                  r_ovalid, n_ovalid;
    logic [rws_pkg::PIDX_BITS-1:0]         r_o_idx, n_o_idx;
    logic [rws_pkg::CHROM_BITS-1:0]        r_o_val, n_o_val;
    logic [rws_pkg::STATUS_BITS-1:0]       r_o_st, n_o_st;

    logic                                  in_acc;
    logic [rws_pkg::SUM_BITS:0]            div_trial;
    logic [rws_pkg::SUM_BITS:0]            div_diff;
    logic [rws_pkg::IDX_BITS-1:0]          mid;
    logic [rws_pkg::SUM_BITS-1:0]          load_sum;
    logic                                  ram_we;
    logic [rws_pkg::IDX_BITS-1:0]          ram_waddr;
    logic [rws_pkg::IDX_BITS-1:0]          ram_raddr;
    logic [rws_pkg::VALUE_BITS-1:0]        val_rdata;
    logic [rws_pkg::SUM_BITS-1:0]          cum_rdata;

    rws_ram #(
        .WIDTH (rws_pkg::VALUE_BITS),
        .DEPTH (rws_pkg::MAX_POP)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_chrom),
        .i_raddr (ram_raddr),
        .o_rdata (val_rdata)
    );

    rws_ram #(
        .WIDTH (rws_pkg::SUM_BITS),
        .DEPTH (rws_pkg::MAX_POP)
    ) u_cumulative (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (load_sum),
        .i_raddr (ram_raddr),
        .o_rdata (cum_rdata)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign in_acc             = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.picked_index = r_o_idx;
    assign o_out.picked_value = r_o_val;
    assign o_out.status       = r_o_st;

    // restoring subtract step of the draw modulo total
    assign div_trial = {r_rem, r_draw[rws_pkg::DRAW_BITS-1]};
    assign div_diff  = div_trial - {1'b0, r_total};

    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign load_sum  = r_total + rws_pkg::SUM_BITS'(r_prod);
    assign ram_we    = (r_state == S_LOAD_ADD);
    assign ram_waddr = r_count[rws_pkg::IDX_BITS-1:0];
    assign ram_raddr = ((r_state == S_SADDR) && (r_lo < r_hi)) ? mid : r_lo;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_total   = r_total;
        n_chrom   = r_chrom;
        n_prod    = r_prod;
        n_draw    = r_draw;
        n_rem     = r_rem;
        n_div_cnt = r_div_cnt;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_res_idx = r_res_idx;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid;
        n_o_idx   = r_o_idx;
        n_o_val   = r_o_val;
        n_o_st    = r_o_st;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_chrom   = i_in.chromosome[rws_pkg::VALUE_BITS-1:0];
                    n_draw    = i_in.draw;
                    n_res_idx = '0;
                    n_res_val = '0;
                    n_res_st  = rws_pkg::ST_OK;
                    n_state   = S_RESP;
                    case (i_in.action)
                        rws_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                        end
                        rws_pkg::ACT_LOAD: begin
                            if (r_count >= rws_pkg::CNT_BITS'(rws_pkg::MAX_POP)) begin
                                n_res_st = rws_pkg::ST_FULL;
                            end else begin
                                n_state = S_LOAD_MUL;
                            end
                        end
                        rws_pkg::ACT_SELECT: begin
                            if ((r_count == '0) || (r_total == '0)) begin
                                n_res_st = rws_pkg::ST_EMPTY;
                            end else begin
                                n_rem     = '0;
                                n_div_cnt = '0;
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD_MUL: begin
                n_prod  = r_chrom * r_chrom;
                n_state = S_LOAD_ADD;
            end
            S_LOAD_ADD: begin
                n_total = load_sum;
                n_count = r_count + 1'b1;
                n_state = S_RESP;
            end
            S_DIV: begin
                if (!div_diff[rws_pkg::SUM_BITS]) begin
                    n_rem = div_diff[rws_pkg::SUM_BITS-1:0];
                end else begin
                    n_rem = div_trial[rws_pkg::SUM_BITS-1:0];
                end
                n_draw    = r_draw << 1;
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == rws_pkg::DIV_CNT_BITS'(rws_pkg::DRAW_BITS - 1)) begin
                    n_lo    = '0;
                    n_hi    = rws_pkg::IDX_BITS'(r_count - 1'b1);
                    n_state = S_SADDR;
                end
            end
            S_SADDR: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid;
                    n_state = S_SCMP;
                end else begin
                    n_state = S_FWAIT;
                end
            end
            S_SCMP: begin
                if (cum_rdata > r_rem) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + 1'b1;
                end
                n_state = S_SADDR;
            end
            S_FWAIT: begin
                n_res_idx = rws_pkg::PIDX_BITS'(r_lo);
                n_res_val = rws_pkg::CHROM_BITS'(val_rdata);
                n_res_st  = rws_pkg::ST_OK;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_o_idx  = r_res_idx;
                    n_o_val  = r_res_val;
                    n_o_st   = r_res_st;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chrom   <= n_chrom;
        r_prod    <= n_prod;
        r_draw    <= n_draw;
        r_rem     <= n_rem;
        r_div_cnt <= n_div_cnt;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_res_idx <= n_res_idx;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_o_idx   <= n_o_idx;
        r_o_val   <= n_o_val;
        r_o_st    <= n_o_st;
    end

    // population never exceeds the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rws_pkg::CNT_BITS'(rws_pkg::MAX_POP))
        else $error("population count above table depth");

    // the modulo leaves a remainder below the total
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SADDR) |-> (r_rem < r_total))
        else $error("remainder not below total during search");

    // a compare step only runs on a non-empty range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |-> (r_lo < r_hi))
        else $error("search compare on empty range");

    // the picked individual lies inside the population
    a_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWAIT) |-> (rws_pkg::CNT_BITS'(r_lo) < r_count))
        else $error("picked index outside population");

    // a result is committed only into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready && (r_state == S_RESP)) |=> (r_state == S_RESP))
        else $error("stalled result overwritten");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench of roulette_wheel_selector_top: a directed table of clear, load,
// select and unused-code words, then random populations filled and sampled
// in pairs, with noise and up to two fills past the population limit. every
// accepted word is run through a local wheel model and each result word is
// compared field by field, in order. the sender works in bursts and the
// receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rws_pkg::ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1400;
    localparam int DIRECTED_N   = 19;

    typedef struct packed {
        logic [rws_pkg::ACTION_BITS-1:0] action;
        logic [rws_pkg::CHROM_BITS-1:0]  chrom;
        logic [rws_pkg::DRAW_BITS-1:0]   draw;
        logic                            typed;
        logic [rws_pkg::PIDX_BITS-1:0]   idx;
        logic [rws_pkg::CHROM_BITS-1:0]  val;
        logic [rws_pkg::STATUS_BITS-1:0] st;
    } t_cmd;

    typedef struct packed {
        logic [rws_pkg::PIDX_BITS-1:0]   idx;
        logic [rws_pkg::CHROM_BITS-1:0]  val;
        logic [rws_pkg::STATUS_BITS-1:0] st;
    } t_pick;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rws_in_if  in_if ();
    rws_out_if out_if ();

    roulette_wheel_selector_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // wheel state
    logic [rws_pkg::CHROM_BITS-1:0] pop_value [rws_pkg::MAX_POP];
    logic [rws_pkg::SUM_BITS-1:0]   pop_cum [rws_pkg::MAX_POP];
    logic [rws_pkg::CNT_BITS-1:0]   pop_count = '0;
    logic [rws_pkg::SUM_BITS-1:0]   pop_total = '0;

    t_cmd  cmd_q [$];
    t_pick picks_due [$];
    t_cmd  cur_cmd;
    int    mismatches = 0;

    logic [15:0] stall_pat;
    logic [3:0]  stall_phase;

    t_cmd directed_tab [DIRECTED_N] = '{
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_EMPTY},
        '{rws_pkg::ACT_LOAD,   16'h0000, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'h0000_0000_007B,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_EMPTY},
        '{rws_pkg::ACT_LOAD,   16'hFFFF, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'h0000_0000_0000,
          1'b1, 8'd1, 16'hFFFF, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
          1'b1, 8'd1, 16'hFFFF, rws_pkg::ST_OK},
        '{rws_pkg::ACT_LOAD,   16'h0001, 48'hFFFF_FFFF_FFFF,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_LOAD,   16'h8000, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'h0000_0000_0000,
          1'b0, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'hFFFF_FFFF_FFFF,
          1'b0, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'h0000_FFFE_0001,
          1'b0, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{ACT_UNUSED,          16'hFFFF, 48'hFFFF_FFFF_FFFF,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_LOAD,   16'hAAAA, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'h5555_5555_5555,
          1'b0, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_CLEAR,  16'hFFFF, 48'hFFFF_FFFF_FFFF,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'hFFFF_FFFF_FFFF,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_EMPTY},
        '{rws_pkg::ACT_LOAD,   16'h5555, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK},
        '{rws_pkg::ACT_SELECT, 16'h0000, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h5555, rws_pkg::ST_OK},
        '{rws_pkg::ACT_CLEAR,  16'h0000, 48'h0000_0000_0000,
          1'b1, 8'd0, 16'h0000, rws_pkg::ST_OK}
    };

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns mismatch on %s: got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic t_pick spin_wheel(logic [rws_pkg::ACTION_BITS-1:0] action,
                                         logic [rws_pkg::CHROM_BITS-1:0] chrom,
                                         logic [rws_pkg::DRAW_BITS-1:0] draw);
        t_pick                        res;
        logic [rws_pkg::SUM_BITS-1:0] fit;
        logic [63:0]                  landing;
        logic [rws_pkg::IDX_BITS-1:0] lo;
        logic [rws_pkg::IDX_BITS-1:0] hi;
        logic [rws_pkg::IDX_BITS-1:0] mid;
        res = '0;
        case (action)
            rws_pkg::ACT_CLEAR: begin
                pop_count = '0;
                pop_total = '0;
            end
            rws_pkg::ACT_LOAD: begin
                if (pop_count >= rws_pkg::CNT_BITS'(rws_pkg::MAX_POP)) begin
                    res.st = rws_pkg::ST_FULL;
                end else begin
                    fit = rws_pkg::SUM_BITS'(chrom) * rws_pkg::SUM_BITS'(chrom);
                    pop_total = pop_total + fit;
                    pop_value[pop_count[rws_pkg::IDX_BITS-1:0]] = chrom;
                    pop_cum[pop_count[rws_pkg::IDX_BITS-1:0]] = pop_total;
                    pop_count = pop_count + 1'b1;
                end
            end
            rws_pkg::ACT_SELECT: begin
                if (pop_count == '0 || pop_total == '0) begin
                    res.st = rws_pkg::ST_EMPTY;
                end else begin
                    landing = 64'(draw) % 64'(pop_total);
                    lo = '0;
                    hi = rws_pkg::IDX_BITS'(pop_count - 1'b1);
                    while (lo < hi) begin
                        mid = lo + ((hi - lo) >> 1);
                        if (64'(pop_cum[mid]) > landing) hi = mid;
                        else lo = mid + 1'b1;
                    end
                    res.idx = rws_pkg::PIDX_BITS'(lo);
                    res.val = pop_value[lo];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void queue_word(logic [rws_pkg::ACTION_BITS-1:0] action,
                                       logic [rws_pkg::CHROM_BITS-1:0] chrom,
                                       logic [rws_pkg::DRAW_BITS-1:0] draw);
        t_cmd c;
        c = '{action, chrom, draw, 1'b0, 8'd0, 16'd0, rws_pkg::ST_OK};
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    function automatic logic [rws_pkg::CHROM_BITS-1:0] pick_chrom();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return rws_pkg::CHROM_BITS'($urandom_range(1, 15));
            2: return '1;
            default: return rws_pkg::CHROM_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [rws_pkg::DRAW_BITS-1:0] pick_draw();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return rws_pkg::DRAW_BITS'($urandom_range(0, 255));
            default: return rws_pkg::DRAW_BITS'({$urandom, $urandom});
        endcase
    endfunction

    always @(posedge clk) begin : take_word
        t_pick due;
        if (rst_n && in_if.valid && in_if.ready) begin
            due = spin_wheel(in_if.action, in_if.chromosome, in_if.draw);
            if (cur_cmd.typed) due = '{cur_cmd.idx, cur_cmd.val, cur_cmd.st};
            picks_due.insert(picks_due.size(), due);
        end
    end

    always @(posedge clk) begin : check_word
        t_pick want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (picks_due.size() == 0) begin
                report_mismatch("result with nothing due", out_if.status, 0);
            end else begin
                want = picks_due.pop_front();
                if (out_if.picked_index !== want.idx)
                    report_mismatch("picked_index", out_if.picked_index, want.idx);
                if (out_if.picked_value !== want.val)
                    report_mismatch("picked_value", out_if.picked_value, want.val);
                if (out_if.status !== want.st)
                    report_mismatch("status", out_if.status, want.st);
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            stall_phase  <= '0;
            stall_pat    <= '1;
        end else begin
            out_if.ready <= stall_pat[stall_phase];
            stall_phase  <= stall_phase + 1'b1;
            if (stall_phase == 4'd15)
                stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int   kind;
        int   full_runs;
        int   burst_left;
        int   gap;
        t_cmd w;
        in_if.valid      = 1'b0;
        in_if.action     = rws_pkg::ACT_CLEAR;
        in_if.chromosome = '0;
        in_if.draw       = '0;
        cur_cmd          = '0;

        for (int i = 0; i < DIRECTED_N; i++) cmd_q.insert(cmd_q.size(), directed_tab[i]);

        full_runs = 0;
        while (cmd_q.size() < DIRECTED_N + RANDOM_WORDS) begin
            kind = $urandom_range(0, 39);
            if (full_runs == 0 || (kind == 0 && full_runs < 2)) begin
                // fill to the limit, then loads that must be refused
                full_runs++;
                queue_word(rws_pkg::ACT_CLEAR, rws_pkg::CHROM_BITS'($urandom), pick_draw());
                repeat (rws_pkg::MAX_POP + 3)
                    queue_word(rws_pkg::ACT_LOAD, pick_chrom(), pick_draw());
                repeat (8)
                    queue_word(rws_pkg::ACT_SELECT, rws_pkg::CHROM_BITS'($urandom),
                               pick_draw());
            end else if (kind < 8) begin
                repeat ($urandom_range(1, 6))
                    queue_word(rws_pkg::ACTION_BITS'($urandom),
                               rws_pkg::CHROM_BITS'($urandom),
                               rws_pkg::DRAW_BITS'({$urandom, $urandom}));
            end else begin
                if ($urandom_range(0, 3) != 0)
                    queue_word(rws_pkg::ACT_CLEAR, rws_pkg::CHROM_BITS'($urandom),
                               pick_draw());
                repeat ($urandom_range(1, 24))
                    queue_word(rws_pkg::ACT_LOAD, pick_chrom(), pick_draw());
                repeat (2 * $urandom_range(1, 6))
                    queue_word(rws_pkg::ACT_SELECT, rws_pkg::CHROM_BITS'($urandom),
                               pick_draw());
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        burst_left = 0;
        foreach (cmd_q[n]) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            w = cmd_q[n];
            in_if.valid      <= 1'b1;
            in_if.action     <= w.action;
            in_if.chromosome <= w.chrom;
            in_if.draw       <= w.draw;
            cur_cmd          <= w;
            @(posedge clk);
            while (!in_if.ready) @(posedge clk);
            burst_left--;
        end
        in_if.valid <= 1'b0;

        @(posedge clk);
        while (picks_due.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
src/rws_pkg.sv
src/rws_in_if.sv
src/rws_out_if.sv
src/rws_ram.sv
src/roulette_wheel_selector_top.sv
bench/tb.sv
